/* rtl/bc1_pkg.sv */
// Shared types and arithmetic helpers for the BC1 block decoder.
// Used by every module of the decoder; depends on nothing.
`default_nettype none

package bc1_pkg;

    // Depth of the queue between the front and the back part
    localparam int QUEUE_DEPTH = 2;
    localparam int PIXELS_PER_BLOCK = 16;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [15:0] endpoint_zero;
        logic [15:0] endpoint_one;
        logic [31:0] index_bits;
    } block_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] pixel_row;
        logic [1:0] pixel_column;
        logic       last_pixel;
    } pixel_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    // Block after endpoint expansion and mode classification
    typedef struct packed {
        color_t      c0;
        color_t      c1;
        logic        four;
        logic [31:0] index_bits;
    } decoded_t;

    // v*255/31, truncated: 8v plus floor(7v/31), found by thresholds
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [2:0] frac;
        begin
            frac = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
                 + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
            widen5 = {v, 3'b000} + {5'd0, frac};
        end
    endfunction

    // v*255/63, truncated: 4v plus floor(v/21)
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [1:0] frac;
        begin
            frac = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
            widen6 = {v, 2'b00} + {6'd0, frac};
        end
    endfunction

    function automatic color_t unpack565(input logic [15:0] c);
        color_t col;
        begin
            col.red   = widen5(c[15:11]);
            col.green = widen6(c[10:5]);
            col.blue  = widen5(c[4:0]);
            unpack565 = col;
        end
    endfunction

    // floor(x/3) for x below 768: multiply by 683, drop 11 bits
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        begin
            prod = {10'd0, x} * 20'd683;
            div3 = prod[18:11];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/bc1_front.sv */
// Front part of the BC1 decoder: accepts block words, expands endpoints, picks the mode.
// Depends on bc1_pkg.
`default_nettype none

module bc1_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire bc1_pkg::block_word_t block,
    output logic                      q_push,
    input  wire logic                 q_full,
    output bc1_pkg::decoded_t         q_data
);

    logic              valid_reg;
    logic              valid_next;
    bc1_pkg::decoded_t data_reg;
    bc1_pkg::decoded_t data_next;
    logic              accept;

    assign q_push = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_data = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        data_next            = data_reg;
        if (accept)
        begin
            data_next.c0         = bc1_pkg::unpack565(block.endpoint_zero);
            data_next.c1         = bc1_pkg::unpack565(block.endpoint_one);
            // strict compare: equal endpoints mean three-color mode
            data_next.four       = block.endpoint_zero > block.endpoint_one;
            data_next.index_bits = block.index_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

/* rtl/bc1_queue.sv */
// Short register queue of decoded blocks between the front and back parts.
// Depends on bc1_pkg.
`default_nettype none

module bc1_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire bc1_pkg::decoded_t  wr_data,
    output logic                    is_full,
    input  wire logic               rd_en,
    output logic                    rd_valid,
    output bc1_pkg::decoded_t       rd_data
);

    localparam int PTR_W = (bc1_pkg::QUEUE_DEPTH > 1) ? $clog2(bc1_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(bc1_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(bc1_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(bc1_pkg::QUEUE_DEPTH);

    bc1_pkg::decoded_t entry_reg [bc1_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_wr;
    logic              do_rd;

    assign is_full  = count_reg == DEPTH_CNT;
    assign rd_valid = count_reg != '0;
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/bc1_back.sv */
// Back part of the BC1 decoder: builds the palette and emits sixteen pixel words.
// Depends on bc1_pkg.
`default_nettype none

module bc1_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire bc1_pkg::decoded_t    q_data,
    output logic                      q_pop,
    output logic                      empty,
    input  wire logic                 pop,
    output bc1_pkg::pixel_word_t      pixel
);

    localparam int CNT_W = $clog2(bc1_pkg::PIXELS_PER_BLOCK);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(bc1_pkg::PIXELS_PER_BLOCK - 1);

    bc1_pkg::color_t      pal_reg [4];
    bc1_pkg::color_t      pal_next [4];
    logic                 four_reg;
    logic [31:0]          idx_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    bc1_pkg::pixel_word_t out_reg;
    bc1_pkg::pixel_word_t out_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 advance;
    logic                 emit;
    logic                 is_last;
    logic                 load;
    logic [1:0]           sel;

    assign advance = !out_valid_reg || pop;
    assign emit    = busy_reg && advance;
    assign is_last = cnt_reg == LAST_CNT;
    assign load    = q_valid && (!busy_reg || (emit && is_last));
    assign q_pop   = load;
    assign empty   = !out_valid_reg;
    assign pixel   = out_reg;
    assign sel     = idx_reg[{cnt_reg, 1'b0} +: 2];

    // Palette from the queue head: interpolate per channel; entry 3 is black in three-color mode
    always_comb
    begin
        logic [9:0] a;
        logic [9:0] b;
        logic [9:0] sum_a;
        logic [9:0] sum_b;
        logic [8:0] half;
        pal_next[0] = q_data.c0;
        pal_next[1] = q_data.c1;
        pal_next[2] = '0;
        pal_next[3] = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            a     = {2'b00, q_data.c0[ch*8 +: 8]};
            b     = {2'b00, q_data.c1[ch*8 +: 8]};
            sum_a = (a << 1) + b + 10'd1;
            sum_b = a + (b << 1) + 10'd1;
            half  = a[8:0] + b[8:0];
            if (q_data.four)
            begin
                pal_next[2][ch*8 +: 8] = bc1_pkg::div3(sum_a);
                pal_next[3][ch*8 +: 8] = bc1_pkg::div3(sum_b);
            end
            else
            begin
                pal_next[2][ch*8 +: 8] = half[8:1];
                pal_next[3][ch*8 +: 8] = 8'd0;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_next.red          = pal_reg[sel].red;
            out_next.green        = pal_reg[sel].green;
            out_next.blue         = pal_reg[sel].blue;
            // transparent black on index 3 in three-color mode
            out_next.alpha        = (sel == 2'd3 && !four_reg) ? 8'd0 : bc1_pkg::ALPHA_OPAQUE;
            out_next.pixel_row    = cnt_reg[3:2];
            out_next.pixel_column = cnt_reg[1:0];
            out_next.last_pixel   = is_last;
            out_valid_next        = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (load)
        begin
            pal_reg  <= pal_next;
            four_reg <= q_data.four;
            idx_reg  <= q_data.index_bits;
        end
    end

endmodule

`default_nettype wire

/* rtl/bc1_block_decoder.sv */
// BC1 (DXT1) block decoder, top level: front part, block queue, back part.
// Depends on bc1_pkg, bc1_front, bc1_queue and bc1_back.
//
// Input channel: a block word (two RGB565 endpoints and sixteen 2-bit
// indices) is taken at a clock edge with push high and full low.
// Output channel: sixteen pixel words per block, raster order within the
// 4x4 block, the sixteenth marked by last_pixel. The oldest pixel word
// stands on pixel while empty is low and is taken at an edge with pop high.
// Into an idle decoder, a block passes the front register, the block queue
// and the back part's palette register before its first pixel word shows.
// Throughput: one pixel word per cycle while the receiver pops, via the back
// part's single pixel output register. The front register and a two-entry
// block queue take up to three further blocks while one is being emitted.
// When the receiver stalls, the pixel word holds, the back part stops, and
// full rises once the queue and the front register are occupied.
// Reset clears all valid state: full and empty report an empty decoder.
`default_nettype none

module bc1_block_decoder (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire bc1_pkg::block_word_t block,
    output logic                      empty,
    input  wire logic                 pop,
    output bc1_pkg::pixel_word_t      pixel
);

    logic              fq_push;
    logic              fq_full;
    bc1_pkg::decoded_t fq_data;
    logic              qb_valid;
    logic              qb_pop;
    bc1_pkg::decoded_t qb_data;

    bc1_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .block  (block),
        .q_push (fq_push),
        .q_full (fq_full),
        .q_data (fq_data)
    );

    bc1_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fq_push),
        .wr_data  (fq_data),
        .is_full  (fq_full),
        .rd_en    (qb_pop),
        .rd_valid (qb_valid),
        .rd_data  (qb_data)
    );

    bc1_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_data  (qb_data),
        .q_pop   (qb_pop),
        .empty   (empty),
        .pop     (pop),
        .pixel   (pixel)
    );

endmodule

`default_nettype wire

/* verif/bc1_block_decoder_check.sv */
// Checker for the BC1 block decoder: watches the block and pixel channels,
// predicts sixteen pixel words per accepted block and compares them in order.
// Depends on bc1_pkg for the word types.
`timescale 1ns / 1ps

module bc1_block_decoder_check
    import bc1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire block_word_t block,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire pixel_word_t pixel,
    output int               failures,
    output int               pending_pixels
);

    pixel_word_t expected_pixels[$];
    pixel_word_t want;

    // x*255/max, truncated
    function automatic int unsigned widen_channel(input int unsigned v, input int unsigned top);
        return (v * 255) / top;
    endfunction

    task automatic predict_pixels(input block_word_t w);
        int unsigned c0[3];
        int unsigned c1[3];
        int unsigned pal[4][4];
        bit four;
        int unsigned sel;
        pixel_word_t px;
        begin
            c0[0] = widen_channel(w.endpoint_zero[15:11], 31);
            c0[1] = widen_channel(w.endpoint_zero[10:5], 63);
            c0[2] = widen_channel(w.endpoint_zero[4:0], 31);
            c1[0] = widen_channel(w.endpoint_one[15:11], 31);
            c1[1] = widen_channel(w.endpoint_one[10:5], 63);
            c1[2] = widen_channel(w.endpoint_one[4:0], 31);
            // strict compare: equal endpoints fall into three-colour mode
            four = w.endpoint_zero > w.endpoint_one;
            for (int ch = 0; ch < 3; ch++)
            begin
                pal[0][ch] = c0[ch];
                pal[1][ch] = c1[ch];
                if (four)
                begin
                    pal[2][ch] = (2 * c0[ch] + c1[ch] + 1) / 3;
                    pal[3][ch] = (c0[ch] + 2 * c1[ch] + 1) / 3;
                end
                else
                begin
                    pal[2][ch] = (c0[ch] + c1[ch]) / 2;
                    pal[3][ch] = 0;
                end
            end
            pal[0][3] = 255;
            pal[1][3] = 255;
            pal[2][3] = 255;
            pal[3][3] = four ? 255 : 0;
            for (int i = 0; i < 16; i++)
            begin
                sel = (w.index_bits >> (2 * i)) & 32'h3;
                px.red          = 8'(pal[sel][0]);
                px.green        = 8'(pal[sel][1]);
                px.blue         = 8'(pal[sel][2]);
                px.alpha        = 8'(pal[sel][3]);
                px.pixel_row    = 2'(i / 4);
                px.pixel_column = 2'(i % 4);
                px.last_pixel   = (i == 15);
                expected_pixels.push_back(px);
            end
        end
    endtask

    task automatic report_error(input string msg);
        begin
            $display("%0t ns pixel check: %s", $time, msg);
            failures++;
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] got, input logic [7:0] exp_val);
        begin
            if (got !== exp_val)
                report_error($sformatf("%s got %0h, expected %0h", field, got, exp_val));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                predict_pixels(block);
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                    report_error($sformatf("unexpected pixel word %h", pixel));
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("red", pixel.red, want.red);
                    check_field("green", pixel.green, want.green);
                    check_field("blue", pixel.blue, want.blue);
                    check_field("alpha", pixel.alpha, want.alpha);
                    check_field("pixel_row", 8'(pixel.pixel_row), 8'(want.pixel_row));
                    check_field("pixel_column", 8'(pixel.pixel_column), 8'(want.pixel_column));
                    check_field("last_pixel", 8'(pixel.last_pixel), 8'(want.last_pixel));
                end
            end
            pending_pixels = expected_pixels.size();
        end
    end

    final
    begin
    end

endmodule

/* verif/bc1_block_decoder_test.sv */
// Top of the BC1 block decoder testbench: clock, reset, block stimulus and
// pixel back-pressure; depends on bc1_pkg, bc1_block_decoder and the checker.
`timescale 1ns / 1ps

module bc1_block_decoder_test;
    import bc1_pkg::*;

    localparam int RANDOM_BLOCKS = 81;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    block_word_t block = '0;
    logic        full;
    logic        empty;
    pixel_word_t pixel;
    int          failures;
    int          pending_pixels;
    int          idle_pct = 0;
    int          stall_pct = 0;

    always #4 clk = ~clk;

    bc1_block_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .block (block),
        .empty (empty),
        .pop   (pop),
        .pixel (pixel)
    );

    bc1_block_decoder_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .block          (block),
        .empty          (empty),
        .pop            (pop),
        .pixel          (pixel),
        .failures       (failures),
        .pending_pixels (pending_pixels)
    );

    // Receiver: stall at random per the current phase
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hold the word until it is taken; idle beforehand at random
    task automatic send_block(input block_word_t w);
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                push <= 1'b0;
                block <= {$urandom, $urandom};
                @(posedge clk);
            end
            push <= 1'b1;
            block <= w;
            @(posedge clk);
            while (full)
                @(posedge clk);
        end
    endtask

    function automatic block_word_t random_block();
        block_word_t w;
        int kind;
        begin
            w = {$urandom, $urandom};
            kind = $urandom_range(0, 9);
            case (kind)
                6: w.endpoint_one = w.endpoint_zero;
                7: w.endpoint_one = w.endpoint_zero + 16'($urandom_range(0, 2)) - 16'd1;
                8:
                begin
                    w.endpoint_zero = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    w.endpoint_one = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                9: w.index_bits = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                default: ;
            endcase
            return w;
        end
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 30;
        stall_pct = 50;
        // four-colour mode at the extremes, every index
        send_block({16'hFFFF, 16'h0000, 32'h0000_0000});
        send_block({16'hFFFF, 16'h0000, 32'h5555_5555});
        send_block({16'hFFFF, 16'h0000, 32'hAAAA_AAAA});
        send_block({16'hFFFF, 16'h0000, 32'hFFFF_FFFF});
        send_block({16'hFFFF, 16'h0000, 32'hE4E4_E4E4});
        // three-colour mode, transparent entry included
        send_block({16'h0000, 16'hFFFF, 32'h0000_0000});
        send_block({16'h0000, 16'hFFFF, 32'h5555_5555});
        send_block({16'h0000, 16'hFFFF, 32'hAAAA_AAAA});
        send_block({16'h0000, 16'hFFFF, 32'hFFFF_FFFF});
        send_block({16'h0000, 16'hFFFF, 32'h1B1B_1B1B});
        // equal endpoints take the three-colour path
        send_block({16'h0000, 16'h0000, 32'hE4E4_E4E4});
        send_block({16'hFFFF, 16'hFFFF, 32'hE4E4_E4E4});
        send_block({16'h1234, 16'h1234, 32'hFFFF_FFFF});
        // neighbors around the mode boundary, single channels
        send_block({16'h8001, 16'h8000, 32'hFFFF_FFFF});
        send_block({16'h8000, 16'h8001, 32'hFFFF_FFFF});
        send_block({16'hF800, 16'h07E0, 32'hE4E4_E4E4});
        send_block({16'h07E0, 16'h001F, 32'h4E4E_4E4E});
        send_block({16'h001F, 16'hF81F, 32'h9C9C_9C9C});
        send_block({16'hA5A5, 16'h5A5A, 32'h0123_4567});

        for (int n = 0; n < RANDOM_BLOCKS / 3; n++)
            send_block(random_block());
        idle_pct = 50;
        stall_pct = 30;
        for (int n = 0; n < RANDOM_BLOCKS / 3; n++)
            send_block(random_block());
        idle_pct = 0;
        stall_pct = 0;
        for (int n = 0; n < RANDOM_BLOCKS - 2 * (RANDOM_BLOCKS / 3); n++)
            send_block(random_block());
        push <= 1'b0;

        @(posedge clk);
        while (pending_pixels != 0)
            @(posedge clk);
        // drain: catch any stray pixel words
        repeat (24) @(posedge clk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
